/* design/rmmm_pkg.sv */
// ----------------------------------------------------------------------------
// rmmm_pkg
// Shared types and constants for the rating mean/median/mode core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmmm_pkg;

  localparam int NUM_BINS  = 9;
  localparam int BIN_IDX_W = 4;
  localparam int RATING_W  = 4;
  localparam int OCNT_W    = 8;
  localparam int OSUM_W    = 11;
  localparam int MEAN_W    = 12;
  localparam int FRAC_W    = 8;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_CALC
  } state_t;

  typedef struct packed {
    logic ingest;
    logic start;
    logic calc;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* design/rmmm_ctrl.sv */
// ----------------------------------------------------------------------------
// rmmm_ctrl
// Controller: load phase, closing calculation pass, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmm_ctrl
  import rmmm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_item,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   commit;

  assign accept = in_valid && in_ready;
  assign commit = (state_r == ST_CALC) && stat.done && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && in_last_item) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (commit) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_LOAD);
    cmd.ingest = accept;
    cmd.start  = accept && in_last_item;
    cmd.calc   = (state_r == ST_CALC);
    cmd.commit = commit;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/rmmm_dp.sv */
// ----------------------------------------------------------------------------
// rmmm_dp
// Datapath: histogram bins, count/sum, bin scan for median and mode,
// bit-serial divider for the Q4.8 mean, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmm_dp
  import rmmm_pkg::*;
#(
  parameter int MAX_ITEMS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [RATING_W-1:0] in_response_value,
  output logic [OCNT_W-1:0]   out_item_count,
  output logic [OSUM_W-1:0]   out_rating_total,
  output logic [MEAN_W-1:0]   out_mean_q8,
  output logic [RATING_W-1:0] out_median_value,
  output logic [RATING_W-1:0] out_mode_value,
  output logic [OCNT_W-1:0]   out_mode_count,
  output logic                out_input_error
);

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W  = $clog2(NUM_BINS * MAX_ITEMS + 1);
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]     bins_r [NUM_BINS];
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 err_r, err_nxt;

  logic [BIN_IDX_W-1:0] scan_idx_r;
  logic [CNT_W-1:0]     cum_r;
  logic                 found_r;
  logic [RATING_W-1:0]  med_r;
  logic [RATING_W-1:0]  mode_r;
  logic [CNT_W-1:0]     largest_r;

  logic [DCNT_W-1:0]    div_cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [CNT_W-1:0]     rem_r;
  logic [MEAN_W-1:0]    quo_r;

  logic                 v_ok, room, take;
  logic [BIN_IDX_W-1:0] v_idx, rd_addr;
  logic [CNT_W-1:0]     rd_data;
  logic                 scan_active, div_active;
  logic [CNT_W-1:0]     cum_sum;
  logic [CNT_W:0]       rem_sh;
  logic                 rem_ge;
  logic [CNT_W-1:0]     rem_nxt;
  logic [RATING_W-1:0]  scan_rating;
  logic [31:0]          count_ext, sum_ext, largest_ext;

  // ingest
  assign v_ok  = (in_response_value >= RATING_W'(1)) &&
                 (in_response_value <= RATING_W'(NUM_BINS));
  assign room  = (count_r < CNT_W'(MAX_ITEMS));
  assign take  = cmd.ingest && v_ok && room;
  assign v_idx = v_ok ? BIN_IDX_W'(in_response_value - RATING_W'(1)) : '0;

  assign rd_addr = cmd.calc ? scan_idx_r : v_idx;
  assign rd_data = bins_r[rd_addr];

  assign count_nxt = take ? count_r + CNT_W'(1) : count_r;
  assign sum_nxt   = take ? sum_r + SUM_W'(in_response_value) : sum_r;
  assign err_nxt   = err_r || (cmd.ingest && !take);

  // bin scan
  assign scan_active = cmd.calc && (scan_idx_r != BIN_IDX_W'(NUM_BINS));
  assign cum_sum     = cum_r + rd_data;
  assign scan_rating = RATING_W'(scan_idx_r) + RATING_W'(1);

  // restoring divider, one dividend bit per cycle
  assign div_active = cmd.calc && (div_cnt_r != DCNT_W'(DVD_W));
  assign rem_sh     = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, count_r});
  assign rem_nxt    = rem_ge ? CNT_W'(rem_sh - {1'b0, count_r}) : rem_sh[CNT_W-1:0];

  assign stat.done = cmd.calc && !scan_active && !div_active;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.commit) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bins_r[i] <= '0;
      end
      count_r <= '0;
      sum_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      if (take) bins_r[rd_addr] <= rd_data + CNT_W'(1);
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= BIN_IDX_W'(NUM_BINS);
      div_cnt_r  <= DCNT_W'(DVD_W);
    end else if (cmd.start) begin
      scan_idx_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      if (scan_active) scan_idx_r <= scan_idx_r + BIN_IDX_W'(1);
      if (div_active) div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cum_r     <= '0;
      found_r   <= 1'b0;
      med_r     <= '0;
      mode_r    <= '0;
      largest_r <= '0;
      dvd_r     <= {sum_nxt, FRAC_W'(0)};
      rem_r     <= '0;
      quo_r     <= '0;
    end else begin
      if (scan_active) begin
        cum_r <= cum_sum;
        if (!found_r && (cum_sum > (count_r >> 1))) begin
          found_r <= 1'b1;
          med_r   <= scan_rating;
        end
        if (rd_data > largest_r) begin
          largest_r <= rd_data;
          mode_r    <= scan_rating;
        end
      end
      if (div_active) begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[MEAN_W-2:0], rem_ge};
      end
    end
  end

  assign count_ext   = 32'(count_r);
  assign sum_ext     = 32'(sum_r);
  assign largest_ext = 32'(largest_r);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_count   <= count_ext[OCNT_W-1:0];
      out_rating_total <= sum_ext[OSUM_W-1:0];
      out_mean_q8      <= (count_r == '0) ? '0 : quo_r;
      out_median_value <= med_r;
      out_mode_value   <= mode_r;
      out_mode_count   <= largest_ext[OCNT_W-1:0];
      out_input_error  <= err_r;
    end
  end

endmodule

`default_nettype wire

/* design/rating_mean_median_mode_core.sv */
// ----------------------------------------------------------------------------
// rating_mean_median_mode_core
// Histogram-based count, sum, mean, median and mode of a set of ratings.
// ----------------------------------------------------------------------------
// Ratings 1..9 are taken one per cycle, while in_ready is high, into a
// 9-bin histogram; other values, and ratings beyond MAX_ITEMS, are dropped
// and flag input_error. After the item marked last, a closing pass runs
// before the result is registered, longer if the previous result has not
// yet been taken; its length is set by the bit-serial divider that forms
// the mean, with the 9-bin scan for median and mode running beside it.
// in_ready is low during that pass. A finished result waits in the output
// register while the next set loads; all histogram state clears when the
// result is registered.
`default_nettype none

module rating_mean_median_mode_core
  import rmmm_pkg::*;
#(
  parameter int MAX_ITEMS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [RATING_W-1:0] in_response_value,
  input  logic                in_last_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OCNT_W-1:0]   out_item_count,
  output logic [OSUM_W-1:0]   out_rating_total,
  output logic [MEAN_W-1:0]   out_mean_q8,
  output logic [RATING_W-1:0] out_median_value,
  output logic [RATING_W-1:0] out_mode_value,
  output logic [OCNT_W-1:0]   out_mode_count,
  output logic                out_input_error
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rmmm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rmmm_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_response_value (in_response_value),
    .out_item_count    (out_item_count),
    .out_rating_total  (out_rating_total),
    .out_mean_q8       (out_mean_q8),
    .out_median_value  (out_median_value),
    .out_mode_value    (out_mode_value),
    .out_mode_count    (out_mode_count),
    .out_input_error   (out_input_error)
  );

endmodule

`default_nettype wire

/* design/rmmm_chk.sv */
// ----------------------------------------------------------------------------
// rmmm_chk
// Port-level checks for the rating mean/median/mode core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rmmm_chk
  import rmmm_pkg::*;
#(
  parameter int MAX_ITEMS = 128
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last_item,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OCNT_W-1:0]   out_item_count,
  input logic [OSUM_W-1:0]   out_rating_total,
  input logic [MEAN_W-1:0]   out_mean_q8,
  input logic [RATING_W-1:0] out_median_value,
  input logic [RATING_W-1:0] out_mode_value,
  input logic [OCNT_W-1:0]   out_mode_count,
  input logic                out_input_error
);

  localparam bit NO_WRAP = (MAX_ITEMS < 256);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_count) &&
      $stable(out_rating_total) && $stable(out_mean_q8) && $stable(out_median_value) &&
      $stable(out_mode_value) && $stable(out_mode_count) && $stable(out_input_error))
    else $error("result changed while stalled");

  // after a closing item the next cycle cannot take input
  a_calc_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_item |=> !in_ready)
    else $error("input taken during closing pass");

  // median and mode are both empty or both present, and neither exceeds NUM_BINS
  a_med_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_median_value == '0) == (out_mode_value == '0)) &&
      (out_median_value <= RATING_W'(NUM_BINS)) && (out_mode_value <= RATING_W'(NUM_BINS)))
    else $error("median/mode inconsistent");

  // empty set gives zero statistics
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NO_WRAP && (out_item_count == '0) |->
      (out_mean_q8 == '0) && (out_mode_count == '0) && (out_rating_total == '0))
    else $error("empty set with nonzero statistics");

  // mode count bounded by item count
  a_mode_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NO_WRAP |-> out_mode_count <= out_item_count)
    else $error("mode count above item count");

endmodule

bind rating_mean_median_mode_core rmmm_chk #(.MAX_ITEMS(MAX_ITEMS)) u_chk (.*);

`default_nettype wire
